// File: sv/mfpq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, operation and status codes, and the node store command
// type for the multilevel FIFO priority queue. No dependencies.
package mfpq_pkg;

    localparam int DEF_MAX_LEVELS = 16;
    localparam int DEF_CAPACITY   = 64;

    localparam int VALUE_W  = 32;
    localparam int KIND_W   = 2;
    localparam int PRIO_W   = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] LEVELS_RESET = 5'd16;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Controls from the sequencer to the node store
    typedef struct packed {
        logic rd_en;    // read value and link at rd_addr
        logic val_we;   // write value at val_addr
        logic link_we;  // write link at link_addr
        logic alloc;    // node at val_addr leaves the free list
    } node_cmd_t;

endpackage

// File: sv/mfpq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on mfpq_pkg for field widths.
interface mfpq_req_if import mfpq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         priority_req;

    modport source (output valid, kind, value, priority_req, input ready);
    modport sink   (input valid, kind, value, priority_req, output ready);
endinterface

interface mfpq_rsp_if import mfpq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] head_value;
    logic [PRIO_W-1:0]         head_priority;

    modport source (output valid, status, head_value, head_priority, input ready);
    modport sink   (input valid, status, head_value, head_priority, output ready);
endinterface

// File: sv/mfpq_node_store.sv
`timescale 1ns / 1ps
// Node pool: value and link memories with registered reads.
// Depends on mfpq_pkg. Links of never-allocated nodes follow from a mark.
module mfpq_node_store import mfpq_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  node_cmd_t                     cmd,
    input  logic [$clog2(CAPACITY)-1:0]   rd_addr,
    input  logic [$clog2(CAPACITY)-1:0]   val_addr,
    input  logic [VALUE_W-1:0]            val_data,
    input  logic [$clog2(CAPACITY)-1:0]   link_addr,
    input  logic [$clog2(CAPACITY)-1:0]   link_data,
    output logic [VALUE_W-1:0]            rd_value,
    output logic [$clog2(CAPACITY)-1:0]   rd_link
);

    localparam int AW = $clog2(CAPACITY);
    localparam int MW = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0] val_mem  [CAPACITY];
    logic [AW-1:0]      link_mem [CAPACITY];

    logic [MW-1:0]      mark_reg, mark_next;
    logic [VALUE_W-1:0] value_reg;
    logic [AW-1:0]      mem_link_reg;
    logic [AW-1:0]      seq_link_reg;
    logic               fresh_reg;

    // Advance the mark when the next untouched node is taken
    always_comb
    begin
        mark_next = mark_reg;
        if (cmd.alloc && (MW'(val_addr) == mark_reg))
        begin
            mark_next = mark_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= '0;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    // Read and write the memories
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            value_reg    <= val_mem[rd_addr];
            mem_link_reg <= link_mem[rd_addr];
            seq_link_reg <= (rd_addr == AW'(CAPACITY - 1)) ? '0 : rd_addr + 1'b1;
            fresh_reg    <= (MW'(rd_addr) >= mark_reg);
        end
        if (cmd.val_we)
        begin
            val_mem[val_addr] <= val_data;
        end
        if (cmd.link_we)
        begin
            link_mem[link_addr] <= link_data;
        end
    end

    // Untouched nodes read as linked to the next node in address order, wrapping to 0
    assign rd_value = value_reg;
    assign rd_link  = fresh_reg ? seq_link_reg : mem_link_reg;

endmodule

// File: sv/multilevel_fifo_priority_queue.sv
`timescale 1ns / 1ps
// Strict-priority queue built from per-level FIFO lists in a shared node pool.
// Depends on mfpq_pkg, mfpq_if (mfpq_req_if, mfpq_rsp_if) and mfpq_node_store.
//
//   Channel  Dir  Handshake        Payload
//   req      in   valid/ready      kind, value, priority_req
//   rsp      out  valid/ready      status, head_value, head_priority
//   cfg      in   cfg_we           cfg_wdata (levels_in_use)
//
// Insert: level pointer and free-node link lookup, then update.
// Peek/get: head pointer lookup, then node fetch from the pool.
// Rejected insert, empty peek/get, unused kind: status posted from S_POST.
// The final step waits while the response register is full and not taken.
// After reset no clearing pass runs; untouched node links follow a mark.
module multilevel_fifo_priority_queue import mfpq_pkg::*; #(
    parameter int MAX_LEVELS = DEF_MAX_LEVELS,
    parameter int CAPACITY   = DEF_CAPACITY
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    mfpq_req_if.sink         req,
    mfpq_rsp_if.source       rsp
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int LW    = $clog2(MAX_LEVELS);
    localparam int FW    = $clog2(CAPACITY + 1);
    localparam int LIM_W = ($clog2(MAX_LEVELS + 1) > CFG_W) ? $clog2(MAX_LEVELS + 1) : CFG_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_FETCH = 4'b0100,
        S_POST  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CFG_W-1:0]        levels_reg;
    logic [MAX_LEVELS-1:0]   nonempty_reg, nonempty_next;
    logic [AW-1:0]           free_head_reg, free_head_next;
    logic [FW-1:0]           fill_reg, fill_next;

    logic [KIND_W-1:0]       op_kind_reg;
    logic [VALUE_W-1:0]      op_value_reg;
    logic [LW-1:0]           op_lvl_reg;
    logic [STATUS_W-1:0]     op_status_reg;

    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [VALUE_W-1:0]      out_value_reg;
    logic [PRIO_W-1:0]       out_prio_reg;

    logic [AW-1:0]           heads_mem [MAX_LEVELS];
    logic [AW-1:0]           tails_mem [MAX_LEVELS];
    logic [AW-1:0]           head_rd_reg, tail_rd_reg;

    logic [LW-1:0]           first_lvl, req_lvl, acc_lvl, lvl_rd_addr;
    logic                    any_item, in_range, full, slot_free, accept;
    logic [LIM_W-1:0]        limit;
    logic [STATUS_W-1:0]     acc_status;
    logic                    lvl_rd_en, head_we, tail_we;
    logic [AW-1:0]           head_wdata, tail_wdata;
    logic                    commit, ins_commit;
    logic [STATUS_W-1:0]     res_status;
    logic [VALUE_W-1:0]      res_value;
    logic [PRIO_W-1:0]       res_prio;

    node_cmd_t               node_cmd;
    logic [AW-1:0]           node_rd_addr, link_addr, link_data;
    logic [VALUE_W-1:0]      node_value;
    logic [AW-1:0]           node_link;

    mfpq_node_store #(
        .CAPACITY (CAPACITY)
    ) u_node_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (node_cmd),
        .rd_addr   (node_rd_addr),
        .val_addr  (free_head_reg),
        .val_data  (op_value_reg),
        .link_addr (link_addr),
        .link_data (link_data),
        .rd_value  (node_value),
        .rd_link   (node_link)
    );

    // Find the smallest nonempty level
    always_comb
    begin
        first_lvl = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                first_lvl = LW'(i);
            end
        end
    end

    // Decode the request against the level limit and pool fill
    always_comb
    begin
        any_item  = |nonempty_reg;
        limit     = (LIM_W'(levels_reg) < LIM_W'(MAX_LEVELS)) ? LIM_W'(levels_reg)
                                                              : LIM_W'(MAX_LEVELS);
        in_range  = LIM_W'(req.priority_req) < limit;
        req_lvl   = LW'(req.priority_req);
        full      = (fill_reg == FW'(CAPACITY));
        slot_free = !out_valid_reg || rsp.ready;
        accept    = req.valid && (state_reg == S_IDLE);
        acc_lvl   = (req.kind == KIND_INSERT) ? req_lvl : first_lvl;
    end

    // Sequence lookups, fetches and write-back
    always_comb
    begin
        state_next     = state_reg;
        nonempty_next  = nonempty_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        acc_status     = ST_OK;
        node_cmd       = '0;
        node_rd_addr   = free_head_reg;
        link_addr      = free_head_reg;
        link_data      = free_head_reg;
        lvl_rd_en      = 1'b0;
        lvl_rd_addr    = acc_lvl;
        head_we        = 1'b0;
        tail_we        = 1'b0;
        head_wdata     = free_head_reg;
        tail_wdata     = free_head_reg;
        commit         = 1'b0;
        ins_commit     = 1'b0;
        res_status     = ST_OK;
        res_value      = '0;
        res_prio       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.kind)
                        KIND_INSERT:
                        begin
                            if (!in_range)
                            begin
                                acc_status = ST_RANGE;
                                state_next = S_POST;
                            end
                            else if (full)
                            begin
                                acc_status = ST_FULL;
                                state_next = S_POST;
                            end
                            else
                            begin
                                lvl_rd_en      = 1'b1;
                                node_cmd.rd_en = 1'b1;
                                state_next     = S_LOOK;
                            end
                        end
                        KIND_PEEK, KIND_GET:
                        begin
                            if (!any_item)
                            begin
                                acc_status = ST_EMPTY;
                                state_next = S_POST;
                            end
                            else
                            begin
                                lvl_rd_en  = 1'b1;
                                state_next = S_LOOK;
                            end
                        end
                        default:
                        begin
                            state_next = S_POST;
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                if (op_kind_reg == KIND_INSERT)
                begin
                    // Append the free head node behind the level tail
                    if (slot_free)
                    begin
                        commit          = 1'b1;
                        ins_commit      = 1'b1;
                        node_cmd.val_we = 1'b1;
                        node_cmd.alloc  = 1'b1;
                        free_head_next  = node_link;
                        if (nonempty_reg[op_lvl_reg])
                        begin
                            node_cmd.link_we = 1'b1;
                            link_addr        = tail_rd_reg;
                            link_data        = free_head_reg;
                        end
                        else
                        begin
                            head_we                   = 1'b1;
                            nonempty_next[op_lvl_reg] = 1'b1;
                        end
                        tail_we    = 1'b1;
                        fill_next  = fill_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    node_cmd.rd_en = 1'b1;
                    node_rd_addr   = head_rd_reg;
                    state_next     = S_FETCH;
                end
            end

            S_FETCH:
            begin
                if (slot_free)
                begin
                    commit    = 1'b1;
                    res_value = node_value;
                    res_prio  = PRIO_W'(op_lvl_reg);
                    if (op_kind_reg == KIND_GET)
                    begin
                        // Unlink the head and push it on the free list
                        if (head_rd_reg == tail_rd_reg)
                        begin
                            nonempty_next[op_lvl_reg] = 1'b0;
                        end
                        else
                        begin
                            head_we    = 1'b1;
                            head_wdata = node_link;
                        end
                        node_cmd.link_we = 1'b1;
                        link_addr        = head_rd_reg;
                        link_data        = free_head_reg;
                        free_head_next   = head_rd_reg;
                        fill_next        = fill_reg - 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_POST:
            begin
                if (slot_free)
                begin
                    commit     = 1'b1;
                    res_status = op_status_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            levels_reg    <= LEVELS_RESET;
            nonempty_reg  <= '0;
            free_head_reg <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nonempty_reg  <= nonempty_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            if (cfg_we)
            begin
                levels_reg <= cfg_wdata;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the operation and the response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_kind_reg   <= req.kind;
            op_value_reg  <= req.value;
            op_lvl_reg    <= acc_lvl;
            op_status_reg <= acc_status;
        end
        if (commit)
        begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
            out_prio_reg   <= res_prio;
        end
    end

    // Level head and tail pointer memories
    always_ff @(posedge clk)
    begin
        if (lvl_rd_en)
        begin
            head_rd_reg <= heads_mem[lvl_rd_addr];
            tail_rd_reg <= tails_mem[lvl_rd_addr];
        end
        if (head_we)
        begin
            heads_mem[op_lvl_reg] <= head_wdata;
        end
        if (tail_we)
        begin
            tails_mem[op_lvl_reg] <= tail_wdata;
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.head_value    = out_value_reg;
    assign rsp.head_priority = out_prio_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(CAPACITY))
        else $error("fill count beyond pool capacity");

    a_fetch_level_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> nonempty_reg[op_lvl_reg])
        else $error("fetch from an empty level");

    a_insert_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ins_commit |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("insert did not advance the fill count");

    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (nonempty_reg == '0) |-> (fill_reg == '0))
        else $error("nodes in use while every level is empty");

endmodule
